// ===== hw/rtl/acrr_pkg.sv =====
package acrr_pkg;

  localparam int CHANNEL_COUNT = 8;
  localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_COMPLETE = 2'd1;
  localparam logic [1:0] OP_POLL     = 2'd2;

  typedef logic [CHANNEL_COUNT-1:0] mask_t;
  typedef logic [CH_W-1:0]          chan_t;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] channel;
    logic [9:0] sample;
  } req_item_t;

  typedef struct packed {
    logic       start_valid;
    logic [2:0] start_channel;
    logic       done_valid;
    logic [2:0] done_channel;
    logic [9:0] done_sample;
    logic       busy_res;
  } res_item_t;

  typedef struct packed {
    logic  found;
    chan_t channel;
  } pick_t;

  function automatic logic [2:0] chan_out(input chan_t ch);
    logic [31:0] wide;
    wide = 32'(ch);
    return wide[2:0];
  endfunction

endpackage

// ===== hw/rtl/acrr_if.sv =====
interface acrr_req_if import acrr_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface acrr_res_if import acrr_pkg::*; ();
  logic      valid;
  logic      ready;
  res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/acrr_pick.sv =====
module acrr_pick import acrr_pkg::*; (
  input  mask_t mask,
  input  chan_t cur,
  output pick_t pick
);

  logic [CH_W:0] idx;

  // rotating priority: search starts one past cur, cur itself checked last
  always_comb begin
    pick = '0;
    idx  = '0;
    for (int k = CHANNEL_COUNT; k >= 1; k--) begin
      idx = {1'b0, cur} + (CH_W+1)'(k);
      if (idx >= (CH_W+1)'(CHANNEL_COUNT)) begin
        idx = idx - (CH_W+1)'(CHANNEL_COUNT);
      end
      if (mask[idx[CH_W-1:0]]) begin
        pick.found   = 1'b1;
        pick.channel = idx[CH_W-1:0];
      end
    end
  end

endmodule

// ===== hw/rtl/adc_channel_round_robin_scheduler.sv =====
// Round-robin conversion scheduler for a multichannel converter.
// Channels: req (sink) carries events: schedule a channel, conversion
// complete with its sample, or poll. res (source) carries exactly one result
// per event: the conversion started by it (if any), the delivered sample (if
// any) and the busy flag after the event.
// Each transfer on req is captured in an input register; the scheduler state
// (pending mask, busy flag, current channel) is updated by one pass of logic
// with a rotating priority encoder and the result lands in the output
// register, so each result passes through the input register and then the
// output register before it transfers on res; one event per cycle is
// sustained while the res receiver is ready.
// Reset (rst, synchronous) clears the pending mask, the busy flag, the
// current channel and both register stages.
// When the res receiver stalls, the output register holds its result and the
// input register holds the next event; req stays ready while either stage is
// free or moves in the same cycle.
module adc_channel_round_robin_scheduler import acrr_pkg::*; (
  input logic       clk,
  input logic       rst,
  acrr_req_if.sink  req,
  acrr_res_if.source res
);

  logic      iv;
  req_item_t item;
  logic      ov;
  res_item_t result;

  mask_t pend;
  logic  busy;
  chan_t cur;

  mask_t     pend_next;
  logic      busy_next;
  chan_t     cur_next;
  res_item_t result_next;

  mask_t set_vec;
  mask_t mask_a;
  logic  in_range;
  logic  do_adv;
  logic  adv_s1;
  pick_t pick;

  assign adv_s1    = iv && (!ov || res.ready);
  assign req.ready = !iv || adv_s1;
  assign res.valid = ov;
  assign res.data  = result;

  assign in_range = {1'b0, item.channel} < 5'(CHANNEL_COUNT);

  always_comb begin
    for (int j = 0; j < CHANNEL_COUNT; j++) begin
      set_vec[j] = (item.op == OP_SCHEDULE) && in_range &&
                   ({1'b0, item.channel} == 5'(j));
    end
  end

  assign mask_a = pend | set_vec;

  acrr_pick u_pick (
    .mask (mask_a),
    .cur  (cur),
    .pick (pick)
  );

  always_comb begin
    do_adv      = 1'b0;
    result_next = '0;
    case (item.op)
      OP_SCHEDULE: do_adv = in_range && !busy;
      OP_COMPLETE: begin
        if (busy) begin
          do_adv                   = 1'b1;
          result_next.done_valid   = 1'b1;
          result_next.done_channel = chan_out(cur);
          result_next.done_sample  = item.sample;
        end
      end
      OP_POLL:     do_adv = (mask_a != '0) && !busy;
      default:     do_adv = 1'b0;
    endcase

    pend_next = mask_a;
    busy_next = busy;
    cur_next  = cur;
    if (do_adv) begin
      if (pick.found) begin
        pend_next[pick.channel]   = 1'b0;
        busy_next                 = 1'b1;
        cur_next                  = pick.channel;
        result_next.start_valid   = 1'b1;
        result_next.start_channel = chan_out(pick.channel);
      end else begin
        busy_next = 1'b0;
        cur_next  = '0;
      end
    end
    result_next.busy_res = busy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv   <= 1'b0;
      ov   <= 1'b0;
      pend <= '0;
      busy <= 1'b0;
      cur  <= '0;
    end else begin
      if (req.ready) begin
        iv <= req.valid;
      end
      if (adv_s1) begin
        ov   <= 1'b1;
        pend <= pend_next;
        busy <= busy_next;
        cur  <= cur_next;
      end else if (res.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item <= req.data;
    end
    if (adv_s1) begin
      result <= result_next;
    end
  end

endmodule
